// ----- rtl/spt_pkg.sv -----
// Shared types and constants for the sorted peer table.
// Operation and status codes, field widths and the default capacity.
// No dependencies.
package spt_pkg;

    localparam int SPT_CAPACITY = 64;

    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int KEY_W    = ADDR_W + PORT_W;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_LOOKUP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_SYNCED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_CURRENT = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SRCH_RD  = 6'b000010,
        S_SRCH_CMP = 6'b000100,
        S_SHIFT    = 6'b001000,
        S_COMMIT   = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

endpackage

// ----- rtl/spt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the key store of the sorted peer table; no dependencies.
module spt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sorted_peer_table_core.sv -----
// Sorted peer table: ascending table of {address, port} keys with lookup,
// insert/update, delete and two tracked indices.
// Depends on spt_pkg and spt_ram.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -------------------------------------
//  request   in         i_in_valid / o_in_stall  i_kind, i_ip_addr, i_port_num,
//                                               i_entry_index
//  result    out        o_out_valid / i_out_stall o_status, o_position, o_count_now,
//                                               o_synced_now, o_current_now
//
// Steps: a lookup or add runs a binary search in which each halving step is a
// RAM read state then a compare state. An insert or delete then moves one entry
// per cycle through the single RAM read and write ports, then drains and commits.
// The final state hands each result to the output register. Direct sets and
// rejected requests go straight to the final state. The key RAM needs no clear
// after reset: only entries below the fill count are ever read. The request side
// stalls while an operation runs; a result waits in the output register while
// the next request is taken, and the sequencer holds in its final state only
// until that register is free.
module sorted_peer_table_core #(
    parameter int CAPACITY = spt_pkg::SPT_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request transfer
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [spt_pkg::KIND_W-1:0]        i_kind,
    input  logic [spt_pkg::ADDR_W-1:0]        i_ip_addr,
    input  logic [spt_pkg::PORT_W-1:0]        i_port_num,
    input  logic signed [spt_pkg::INDEX_W-1:0] i_entry_index,
    // result transfer
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [spt_pkg::STATUS_W-1:0]      o_status,
    output logic [spt_pkg::POS_W-1:0]         o_position,
    output logic [spt_pkg::COUNT_W-1:0]       o_count_now,
    output logic signed [spt_pkg::INDEX_W-1:0] o_synced_now,
    output logic signed [spt_pkg::INDEX_W-1:0] o_current_now
);

    import spt_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // RAM address width
    localparam int CW = $clog2(CAPACITY + 1);   // width that holds 0..CAPACITY
    // width for comparing 7-bit index magnitudes (plus one) against counts
    localparam int XW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // sequencer and table state
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic signed [INDEX_W-1:0] r_synced, n_synced;
    logic signed [INDEX_W-1:0] r_current, n_current;

    // held request
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [INDEX_W-1:0] r_idx, n_idx;

    // search bounds and result
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic          r_eq, n_eq;
    logic [CW-1:0] r_pos, n_pos;
    logic [STATUS_W-1:0] r_res, n_res;

    // shift pipeline
    logic          r_up, n_up;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_wptr, n_wptr;
    logic          r_pend, n_pend;
    logic          r_last, n_last;

    // output register
    logic                      r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]       r_o_status, n_o_status;
    logic [POS_W-1:0]          r_o_pos, n_o_pos;
    logic [COUNT_W-1:0]        r_o_count, n_o_count;
    logic signed [INDEX_W-1:0] r_o_synced, n_o_synced;
    logic signed [INDEX_W-1:0] r_o_current, n_o_current;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    // shared helpers
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          key_lt;
    logic          key_eq;
    logic          in_xfer;
    logic          out_free;
    logic [XW-1:0] in_idx_x;
    logic [XW-1:0] count_x;
    logic          inc_synced, inc_current;
    logic          dec_synced, dec_current;

    spt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    // the less-than and equality comparators shared by every search step
    assign key_lt   = (ram_rdata < r_key);
    assign key_eq   = (ram_rdata == r_key);
    assign in_idx_x = XW'(i_entry_index[6:0]);
    assign count_x  = XW'(r_count);

    // tracked index moves: insert bumps an index at or above the slot,
    // saturating at the top; delete pulls down an index above the hole
    assign inc_synced  = !r_synced[7] && (XW'(r_synced[6:0]) >= XW'(r_pos))
                         && (r_synced[6:0] != 7'h7F);
    assign inc_current = !r_current[7] && (XW'(r_current[6:0]) >= XW'(r_pos))
                         && (r_current[6:0] != 7'h7F);
    assign dec_synced  = !r_synced[7] && (r_synced[6:0] > r_idx[6:0]);
    assign dec_current = !r_current[7] && (r_current[6:0] > r_idx[6:0]);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_synced    = r_synced;
        n_current   = r_current;
        n_kind      = r_kind;
        n_key       = r_key;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_eq        = r_eq;
        n_pos       = r_pos;
        n_res       = r_res;
        n_up        = r_up;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_pend      = r_pend;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_pos     = r_o_pos;
        n_o_count   = r_o_count;
        n_o_synced  = r_o_synced;
        n_o_current = r_o_current;

        ram_we    = 1'b0;
        ram_waddr = r_wptr;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_kind = i_kind;
                    n_key  = {i_ip_addr, i_port_num};
                    n_idx  = i_entry_index;
                    n_lo   = '0;
                    n_hi   = r_count;
                    n_eq   = 1'b0;
                    n_pos  = '0;
                    n_res  = ST_INVALID;
                    n_pend = 1'b0;
                    n_last = 1'b0;
                    unique case (i_kind)
                        KIND_LOOKUP, KIND_ADD: begin
                            n_state = S_SRCH_RD;
                        end
                        KIND_DELETE: begin
                            if (!i_entry_index[7] && (in_idx_x < count_x)) begin
                                n_pos = CW'(i_entry_index[6:0]);
                                n_res = ST_DELETED;
                                n_up  = 1'b0;
                                n_ptr = AW'(in_idx_x + XW'(1));
                                // close the gap only if entries sit above it
                                if ((in_idx_x + XW'(1)) < count_x) begin
                                    n_state = S_SHIFT;
                                end else begin
                                    n_state = S_COMMIT;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        KIND_SET_SYNCED: begin
                            n_synced = i_entry_index;
                            n_res    = ST_FOUND;
                            n_state  = S_DONE;
                        end
                        KIND_SET_CURRENT: begin
                            n_current = i_entry_index;
                            n_res     = ST_FOUND;
                            n_state   = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    // fetch the midpoint; compare next cycle
                    ram_raddr = mid[AW-1:0];
                    n_mid     = mid;
                    n_state   = S_SRCH_CMP;
                end else begin
                    // lower bound found; r_eq tells if the slot holds the key
                    n_pos = r_lo;
                    if (r_kind == KIND_LOOKUP) begin
                        n_res   = r_eq ? ST_FOUND : ST_MISS;
                        n_state = S_DONE;
                    end else if (r_eq) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_lo[AW-1:0];
                        ram_wdata = r_key;
                        n_res     = ST_UPDATED;
                        n_state   = S_DONE;
                    end else if (r_count == FULL_COUNT) begin
                        n_res   = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_res = ST_INSERTED;
                        n_up  = 1'b1;
                        n_ptr = AW'(r_count - CW'(1));
                        if (r_count > r_lo) begin
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_COMMIT;
                        end
                    end
                end
            end

            S_SRCH_CMP: begin
                if (key_lt) begin
                    n_lo = CW'(r_mid + CW'(1));
                end else begin
                    n_hi = r_mid;
                    n_eq = key_eq;
                end
                n_state = S_SRCH_RD;
            end

            S_SHIFT: begin
                // write back the entry read last cycle, one slot over
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr;
                    ram_wdata = ram_rdata;
                end
                if (!r_last) begin
                    ram_raddr = r_ptr;
                    n_pend    = 1'b1;
                    n_wptr    = r_up ? AW'(r_ptr + AW'(1)) : AW'(r_ptr - AW'(1));
                    if (r_up ? (CW'(r_ptr) == r_pos)
                             : (CW'(r_ptr) == CW'(r_count - CW'(1)))) begin
                        n_last = 1'b1;
                    end else begin
                        n_ptr = r_up ? AW'(r_ptr - AW'(1)) : AW'(r_ptr + AW'(1));
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_COMMIT;
                end
            end

            S_COMMIT: begin
                if (r_up) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[AW-1:0];
                    ram_wdata = r_key;
                    n_count   = CW'(r_count + CW'(1));
                    if (inc_synced) begin
                        n_synced = r_synced + 8'sd1;
                    end
                    if (inc_current) begin
                        n_current = r_current + 8'sd1;
                    end
                end else begin
                    n_count = CW'(r_count - CW'(1));
                    if (dec_synced) begin
                        n_synced = r_synced - 8'sd1;
                    end
                    if (dec_current) begin
                        n_current = r_current - 8'sd1;
                    end
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res;
                    n_o_pos     = POS_W'(r_pos);
                    n_o_count   = COUNT_W'(r_count);
                    n_o_synced  = r_synced;
                    n_o_current = r_current;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_synced    <= -8'sd1;
            r_current   <= -8'sd1;
            r_pend      <= 1'b0;
            r_last      <= 1'b0;
            r_up        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_synced    <= n_synced;
            r_current   <= n_current;
            r_pend      <= n_pend;
            r_last      <= n_last;
            r_up        <= n_up;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_eq        <= n_eq;
        r_pos       <= n_pos;
        r_res       <= n_res;
        r_ptr       <= n_ptr;
        r_wptr      <= n_wptr;
        r_o_status  <= n_o_status;
        r_o_pos     <= n_o_pos;
        r_o_count   <= n_o_count;
        r_o_synced  <= n_o_synced;
        r_o_current <= n_o_current;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_count_now   = r_o_count;
    assign o_synced_now  = r_o_synced;
    assign o_current_now = r_o_current;

endmodule

// ----- sim/sorted_peer_table_core_test.sv -----
// Self-checking testbench for sorted_peer_table_core: a shadow table predicts every transfer.
// Directed corner cases first, then phased random add, lookup and delete traffic.
// Depends on spt_pkg and the RTL of sorted_peer_table_core.
`timescale 1ns / 1ps

module sorted_peer_table_core_test;
    import spt_pkg::*;

    // Kind codes without a defined operation; the block must ignore them.
    localparam int KIND_FIRST_UNUSED = 5;
    localparam int KIND_LAST         = (1 << KIND_W) - 1;

    localparam int POOL_SIZE      = 96;     // more keys than slots, so the table can fill
    localparam int RANDOM_OPS     = 1400;
    localparam int DRAIN_CYCLES   = 200;    // search plus a full shift, with margin
    localparam int TRACK_SATURATE = 127;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ADDR_W-1:0]         ip_addr;
        logic [PORT_W-1:0]         port_num;
        logic signed [INDEX_W-1:0] entry_index;
        bit                        wait_idle;   // hold off until every result is back
    } t_peer_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic [COUNT_W-1:0]        count_now;
        logic signed [INDEX_W-1:0] synced_now;
        logic signed [INDEX_W-1:0] current_now;
    } t_peer_result;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_in_valid    = 1'b0;
    wire                       o_in_stall;
    logic [KIND_W-1:0]         i_kind        = '0;
    logic [ADDR_W-1:0]         i_ip_addr     = '0;
    logic [PORT_W-1:0]         i_port_num    = '0;
    logic signed [INDEX_W-1:0] i_entry_index = '0;
    wire                       o_out_valid;
    logic                      i_out_stall   = 1'b0;
    wire [STATUS_W-1:0]        o_status;
    wire [POS_W-1:0]           o_position;
    wire [COUNT_W-1:0]         o_count_now;
    wire signed [INDEX_W-1:0]  o_synced_now;
    wire signed [INDEX_W-1:0]  o_current_now;

    sorted_peer_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_ip_addr     (i_ip_addr),
        .i_port_num    (i_port_num),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_count_now   (o_count_now),
        .o_synced_now  (o_synced_now),
        .o_current_now (o_current_now)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the table and the two tracked indices
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_keys [SPT_CAPACITY];
    int               shadow_count   = 0;
    int               shadow_synced  = -1;
    int               shadow_current = -1;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    t_peer_req    pending_reqs[$];      // requests not yet presented to the block
    t_peer_result expected_results[$];  // one entry per request, in request order

    // Cumulative weights per traffic phase: add, lookup, delete, direct set; rest is noise.
    // Phase 0 fills the table, phase 1 drains it, phase 2 mixes.
    int op_mix [3][4] = '{'{70, 85, 90, 95}, '{10, 25, 85, 93}, '{30, 60, 85, 95}};

    int requests_sent  = 0;     // written only by the driver
    int results_seen   = 0;     // written only by the monitor
    int mismatch_count = 0;

    // Lower-bound binary search over the shadow table.
    function automatic int find_slot(input logic [KEY_W-1:0] key, output bit hit);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (shadow_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        hit = (lo < shadow_count) && (shadow_keys[lo] == key);
        return lo;
    endfunction

    // Apply one request to the shadow table and return the result it must produce.
    function automatic t_peer_result apply_peer_op(input t_peer_req req);
        t_peer_result     res;
        logic [KEY_W-1:0] key;
        bit               hit;
        int               slot;
        int               idx;
        int               i;
        key        = {req.ip_addr, req.port_num};
        idx        = int'($signed(req.entry_index));
        slot       = 0;
        hit        = 1'b0;
        res.status = ST_INVALID;
        case (req.kind)
            KIND_LOOKUP: begin
                slot       = find_slot(key, hit);
                res.status = hit ? ST_FOUND : ST_MISS;
            end
            KIND_ADD: begin
                slot = find_slot(key, hit);
                if (hit) begin
                    shadow_keys[slot] = key;
                    res.status        = ST_UPDATED;
                end else if (shadow_count >= SPT_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // open a gap at the insertion point
                    for (i = shadow_count; i > slot; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                    end
                    shadow_keys[slot] = key;
                    shadow_count++;
                    // tracked indices follow their entries, saturating at the top
                    if (shadow_synced >= slot && shadow_synced < TRACK_SATURATE) begin
                        shadow_synced++;
                    end
                    if (shadow_current >= slot && shadow_current < TRACK_SATURATE) begin
                        shadow_current++;
                    end
                    res.status = ST_INSERTED;
                end
            end
            KIND_DELETE: begin
                if (idx >= 0 && idx < shadow_count) begin
                    for (i = idx; i < shadow_count - 1; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                    end
                    shadow_count--;
                    if (shadow_synced > idx) begin
                        shadow_synced--;
                    end
                    if (shadow_current > idx) begin
                        shadow_current--;
                    end
                    slot       = idx;
                    res.status = ST_DELETED;
                end
            end
            KIND_SET_SYNCED: begin
                shadow_synced = idx;
                res.status    = ST_FOUND;
            end
            KIND_SET_CURRENT: begin
                shadow_current = idx;
                res.status     = ST_FOUND;
            end
            default: begin
            end
        endcase
        res.position    = slot[POS_W-1:0];
        res.count_now   = shadow_count[COUNT_W-1:0];
        res.synced_now  = shadow_synced[INDEX_W-1:0];
        res.current_now = shadow_current[INDEX_W-1:0];
        return res;
    endfunction

    // Queue a request together with its predicted result.
    function automatic logic [STATUS_W-1:0] queue_op(
        input logic [KIND_W-1:0]         kind,
        input logic [ADDR_W-1:0]         ip_addr,
        input logic [PORT_W-1:0]         port_num,
        input logic signed [INDEX_W-1:0] entry_index,
        input bit                        wait_idle
    );
        t_peer_req    req;
        t_peer_result res;
        req.kind        = kind;
        req.ip_addr     = ip_addr;
        req.port_num    = port_num;
        req.entry_index = entry_index;
        req.wait_idle   = wait_idle;
        res             = apply_peer_op(req);
        pending_reqs.push_back(req);
        expected_results.push_back(res);
        return res.status;
    endfunction

    // Pick a key: from the live table with the given percentage, else the pool or fresh random.
    function automatic logic [KEY_W-1:0] pick_key(input int table_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < table_pct && shadow_count > 0) begin
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        end else if (r < 80) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return {32'($urandom), 16'($urandom)};
    endfunction

    // Delete index that the block has to refuse.
    function automatic logic signed [INDEX_W-1:0] pick_bad_index();
        case ($urandom_range(0, 3))
            0:       return -1;
            1:       return INDEX_W'(shadow_count);
            2:       return INDEX_W'($urandom_range(shadow_count, TRACK_SATURATE));
            default: return INDEX_W'($urandom_range(128, 255));
        endcase
    endfunction

    // New value for a tracked index: mostly in range, sometimes at the top, sometimes anything.
    function automatic logic signed [INDEX_W-1:0] pick_track_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return INDEX_W'($urandom_range(0, shadow_count + 1) - 1);
        end else if (r < 70) begin
            return INDEX_W'($urandom_range(TRACK_SATURATE - 1, TRACK_SATURATE));
        end
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int                        done_ops;
        int                        phase;
        int                        phase_left;
        int                        r;
        int                        k;
        bit                        first_phase;
        bit                        hold_off;
        logic [KEY_W-1:0]          key;
        logic [KIND_W-1:0]         kind_sel;
        logic signed [INDEX_W-1:0] idx;
        logic [STATUS_W-1:0]       st;

        // Extremes first, then runs of keys that share an address and differ in port.
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {32'h0000_0000, 16'hFFFF};
        key_pool[3] = {32'hFFFF_FFFF, 16'h0000};
        key_pool[4] = {32'h8000_0000, 16'h0001};
        for (k = 5; k < POOL_SIZE; k++) begin
            if (k % 3 == 0) begin
                key_pool[k] = {key_pool[k-1][KEY_W-1:PORT_W], 16'($urandom)};
            end else begin
                key_pool[k] = {32'($urandom), 16'($urandom)};
            end
        end

        // Directed: empty table, extremes, update in place, saturation and refused deletes.
        void'(queue_op(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 0, 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0000_0000, 16'h0000, 0, 1'b0));
        void'(queue_op(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0));
        void'(queue_op(KIND_ADD, 32'h0000_0000, 16'h0000, 0, 1'b0));
        void'(queue_op(KIND_ADD, 32'h0000_0000, 16'hFFFF, 0, 1'b0));
        void'(queue_op(KIND_ADD, 32'hFFFF_FFFF, 16'h0000, 0, 1'b0));
        void'(queue_op(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0));
        void'(queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0));
        void'(queue_op(KIND_LOOKUP, 32'h0000_0001, 16'h0000, 0, 1'b0));
        void'(queue_op(KIND_SET_SYNCED, 32'h0, 16'h0, 2, 1'b0));
        void'(queue_op(KIND_SET_CURRENT, 32'h0, 16'h0, INDEX_W'(TRACK_SATURATE), 1'b0));
        void'(queue_op(KIND_ADD, 32'h8000_0000, 16'h8000, 0, 1'b0));
        void'(queue_op(KIND_SET_CURRENT, 32'h0, 16'h0, INDEX_W'(TRACK_SATURATE - 1), 1'b0));
        void'(queue_op(KIND_ADD, 32'h0000_0000, 16'h0001, 0, 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, -1, 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, INDEX_W'(shadow_count), 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, INDEX_W'(TRACK_SATURATE), 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, -128, 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, 0, 1'b0));
        void'(queue_op(KIND_DELETE, 32'h0, 16'h0, INDEX_W'(shadow_synced), 1'b0));
        for (k = KIND_FIRST_UNUSED; k <= KIND_LAST; k++) begin
            kind_sel = KIND_W'(k);
            void'(queue_op(kind_sel, 32'hA5A5_5A5A, 16'h5A5A, 8'sh55, 1'b0));
        end
        void'(queue_op(KIND_SET_SYNCED, 32'h0, 16'h0, -1, 1'b0));
        void'(queue_op(KIND_SET_CURRENT, 32'h0, 16'h0, -1, 1'b1));

        // Random traffic in phases; the first phase fills the table to capacity.
        done_ops    = 0;
        phase       = 0;
        phase_left  = 0;
        first_phase = 1'b1;
        while (done_ops < RANDOM_OPS) begin
            if (phase_left == 0) begin
                phase       = first_phase ? 0 : $urandom_range(0, 2);
                phase_left  = first_phase ? 250 : $urandom_range(60, 200);
                first_phase = 1'b0;
            end
            phase_left--;
            hold_off = ($urandom_range(0, 199) == 0);
            r        = $urandom_range(0, 99);
            key      = {32'($urandom), 16'($urandom)};
            idx      = 8'($urandom);
            if (r < op_mix[phase][0]) begin
                key = pick_key(0);
                st  = queue_op(KIND_ADD, key[KEY_W-1:PORT_W], key[PORT_W-1:0], idx, hold_off);
            end else if (r < op_mix[phase][1]) begin
                key = pick_key(40);
                st  = queue_op(KIND_LOOKUP, key[KEY_W-1:PORT_W], key[PORT_W-1:0], idx, hold_off);
            end else if (r < op_mix[phase][2]) begin
                if ($urandom_range(0, 99) < 85 && shadow_count > 0) begin
                    idx = INDEX_W'($urandom_range(0, shadow_count - 1));
                end else begin
                    idx = pick_bad_index();
                end
                st = queue_op(KIND_DELETE, key[KEY_W-1:PORT_W], key[PORT_W-1:0], idx, hold_off);
            end else if (r < op_mix[phase][3]) begin
                kind_sel = $urandom_range(0, 1) ? KIND_SET_SYNCED : KIND_SET_CURRENT;
                st = queue_op(kind_sel, key[KEY_W-1:PORT_W], key[PORT_W-1:0],
                              pick_track_index(), hold_off);
            end else begin
                // noise: undefined kinds and refused deletes
                if ($urandom_range(0, 1)) begin
                    kind_sel = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST));
                end else begin
                    kind_sel = KIND_DELETE;
                    idx      = pick_bad_index();
                end
                st = queue_op(kind_sel, key[KEY_W-1:PORT_W], key[PORT_W-1:0], idx, hold_off);
            end
            if (st != ST_INVALID) begin
                done_ops++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come back, then let it settle.
        while (!(requests_sent == expected_results.size() && results_seen == requests_sent)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present queued requests in bursts with random gaps
    // ------------------------------------------------------------------
    int        gap_left   = 0;
    int        burst_left = 8;
    bit        req_taken;
    t_peer_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            req_taken = i_in_valid && !o_in_stall;
            if (req_taken) begin
                requests_sent <= requests_sent + 1;
            end
            if (i_in_valid && !req_taken) begin
                // stalled: hold valid and payload
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].wait_idle ||
                          (!req_taken && requests_sent == results_seen))) begin
                next_req = pending_reqs.pop_front();
                i_in_valid    <= 1'b1;
                i_kind        <= next_req.kind;
                i_ip_addr     <= next_req.ip_addr;
                i_port_num    <= next_req.port_num;
                i_entry_index <= next_req.entry_index;
                burst_left--;
                if (burst_left <= 0) begin
                    // occasionally a long burst with no idle cycles at all
                    if ($urandom_range(0, 9) == 0) begin
                        burst_left = $urandom_range(100, 300);
                    end else begin
                        burst_left = $urandom_range(1, 12);
                    end
                    gap_left = $urandom_range(1, 10);
                end
            end else begin
                // nothing to send, or waiting for the block to go idle
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer, and stall on a changing pattern
    // ------------------------------------------------------------------
    int           stall_mode = 0;
    int           stall_left = 0;
    t_peer_result want;

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            mismatch_count++;
            $display("%0t: result %0d %s expected 0x%h got 0x%h",
                     $time, results_seen, field, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (results_seen >= requests_sent) begin
                    mismatch_count++;
                    $display("%0t: result %0d expected none got status 0x%h position 0x%h",
                             $time, results_seen, o_status, o_position);
                end else begin
                    want = expected_results[results_seen];
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("position", 8'(want.position), 8'(o_position));
                    check_field("count_now", 8'(want.count_now), 8'(o_count_now));
                    check_field("synced_now", want.synced_now, o_synced_now);
                    check_field("current_now", want.current_now, o_current_now);
                end
                results_seen <= results_seen + 1;
            end

            // Stall modes: none, light, heavy, alternating.
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 150);
            end
            stall_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= !i_out_stall;
            endcase
        end
    end

endmodule
